FILE: src/wffh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wffh_pkg
// Shared types, codes and constants of the 802.11 frame header filter.
// ----------------------------------------------------------------------------
package wffh_pkg;

    // field widths
    localparam int ADDR_W    = 48;
    localparam int LEN_W     = 12;
    localparam int OUI_W     = 24;
    localparam int RSSI_W    = 8;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int HDR_W     = 5;
    localparam int PAY_OUT_W = 7;
    localparam int CNT_OUT_W = 7;
    localparam int SEEN_W    = 32;

    // parameter defaults
    localparam int LOG_DEPTH_DEF   = 64;
    localparam int PAYLOAD_MAX_DEF = 64;

    // frame kind codes
    localparam logic [1:0] KIND_MGMT = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_ON    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_BEACONS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BSSID_ON      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BSSID_VALUE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ON     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VALUE  = 3'd6;

    // header constants
    localparam int          MIN_FRAME_LEN  = 24;
    localparam int          MESH_MIN_LEN   = 32;
    localparam logic [3:0]  SUBTYPE_BEACON = 4'd8;
    localparam logic [3:0]  SUBTYPE_PROBE  = 4'd4;
    localparam logic [3:0]  SUBTYPE_ACTION = 4'd13;
    localparam logic [23:0] MESH_OUI       = 24'hE09AF6;
    localparam logic [7:0]  QOS_MASK       = 8'h8C;
    localparam logic [7:0]  QOS_MATCH      = 8'h88;
    localparam logic [HDR_W-1:0] HDR_BASIC = 5'd24;
    localparam logic [HDR_W-1:0] HDR_QOS   = 5'd26;

    typedef enum logic [1:0] {
        MODE_ALL  = 2'd0,
        MODE_MGMT = 2'd1,
        MODE_DATA = 2'd2,
        MODE_MESH = 2'd3
    } filter_mode_t;

    typedef enum logic [1:0] {
        CLS_MGMT = 2'd0,
        CLS_DATA = 2'd1,
        CLS_MESH = 2'd2
    } frame_class_t;

    typedef struct packed {
        logic              capture_on;
        filter_mode_t      filter_mode;
        logic              drop_beacons;
        logic              bssid_filter_on;
        logic [ADDR_W-1:0] bssid_value;
        logic              target_filter_on;
        logic [ADDR_W-1:0] target_value;
    } cfg_t;

    typedef struct packed {
        logic [1:0]               frame_kind;
        logic [7:0]               frame_ctrl_low;
        logic [ADDR_W-1:0]        address_one;
        logic [ADDR_W-1:0]        address_two;
        logic [ADDR_W-1:0]        address_three;
        logic [LEN_W-1:0]         frame_length;
        logic [OUI_W-1:0]         vendor_oui;
        logic signed [RSSI_W-1:0] signal_rssi;
    } item_t;

    typedef struct packed {
        logic                 seen;
        logic                 logged;
        frame_class_t         frame_class;
        logic [3:0]           frame_subtype;
        logic [HDR_W-1:0]     header_length;
        logic [PAY_OUT_W-1:0] payload_length;
        logic signed [RSSI_W-1:0] rssi;
    } decision_t;

    typedef struct packed {
        logic [SEEN_W-1:0]        seen_total;
        logic [CNT_OUT_W-1:0]     logged_total;
        logic [CNT_OUT_W-1:0]     mgmt_total;
        logic [CNT_OUT_W-1:0]     data_total;
        logic [CNT_OUT_W-1:0]     mesh_total;
        logic                     log_full;
        logic signed [RSSI_W-1:0] last_rssi;
    } report_t;

endpackage

FILE: src/wffh_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wffh_cfg_regs
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
module wffh_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [wffh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wffh_pkg::CFG_W-1:0]     cfg_data,
    output wffh_pkg::cfg_t                 cfg
);

    wffh_pkg::cfg_t cfg_reg;
    wffh_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                wffh_pkg::CFG_CAPTURE_ON:   cfg_next.capture_on = cfg_data[0];
                wffh_pkg::CFG_FILTER_MODE:
                    cfg_next.filter_mode = wffh_pkg::filter_mode_t'(cfg_data[1:0]);
                wffh_pkg::CFG_DROP_BEACONS: cfg_next.drop_beacons = cfg_data[0];
                wffh_pkg::CFG_BSSID_ON:     cfg_next.bssid_filter_on = cfg_data[0];
                wffh_pkg::CFG_BSSID_VALUE:
                    cfg_next.bssid_value = cfg_data[wffh_pkg::ADDR_W-1:0];
                wffh_pkg::CFG_TARGET_ON:    cfg_next.target_filter_on = cfg_data[0];
                wffh_pkg::CFG_TARGET_VALUE:
                    cfg_next.target_value = cfg_data[wffh_pkg::ADDR_W-1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capture_on       <= 1'b0;
            cfg_reg.filter_mode      <= wffh_pkg::MODE_ALL;
            cfg_reg.drop_beacons     <= 1'b1;
            cfg_reg.bssid_filter_on  <= 1'b0;
            cfg_reg.bssid_value      <= '0;
            cfg_reg.target_filter_on <= 1'b0;
            cfg_reg.target_value     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/wffh_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wffh_classify
// Filter rules, classification and length computation for one header item.
// ----------------------------------------------------------------------------
module wffh_classify
#(
    parameter int PAYLOAD_MAX = wffh_pkg::PAYLOAD_MAX_DEF
)
(
    input  wffh_pkg::item_t     item,
    input  wffh_pkg::cfg_t      cfg,
    input  logic                log_full,
    output wffh_pkg::decision_t dec
);

    localparam int LW = wffh_pkg::LEN_W;
    localparam int PW = wffh_pkg::PAY_OUT_W;

    logic [3:0]                subtype;
    logic                      counted;
    logic                      ok;
    logic                      mesh;
    logic                      bssid_hit;
    logic                      target_hit;
    logic [wffh_pkg::HDR_W-1:0] hdr;
    logic [LW-1:0]             pay_diff;
    logic [LW-1:0]             pay_clamped;

    always_comb
    begin
        subtype = item.frame_ctrl_low[7:4];
        counted = cfg.capture_on
                  && (item.frame_length >= LW'(wffh_pkg::MIN_FRAME_LEN))
                  && ((item.frame_kind == wffh_pkg::KIND_MGMT)
                      || (item.frame_kind == wffh_pkg::KIND_DATA));

        bssid_hit  = (item.address_one == cfg.bssid_value)
                     || (item.address_two == cfg.bssid_value)
                     || (item.address_three == cfg.bssid_value);
        target_hit = (item.address_one == cfg.target_value)
                     || (item.address_two == cfg.target_value)
                     || (item.address_three == cfg.target_value);

        mesh = 1'b0;
        if (item.frame_kind == wffh_pkg::KIND_MGMT)
        begin
            ok = 1'b1;
            if (cfg.drop_beacons && ((subtype == wffh_pkg::SUBTYPE_BEACON)
                                     || (subtype == wffh_pkg::SUBTYPE_PROBE)))
                ok = 1'b0;
            else if (cfg.filter_mode == wffh_pkg::MODE_DATA)
                ok = 1'b0;
            else if (cfg.filter_mode == wffh_pkg::MODE_MESH)
            begin
                // mesh vendor action test only applies in mesh mode
                if ((subtype == wffh_pkg::SUBTYPE_ACTION)
                    && (item.frame_length >= LW'(wffh_pkg::MESH_MIN_LEN))
                    && (item.vendor_oui == wffh_pkg::MESH_OUI))
                    mesh = 1'b1;
                else
                    ok = 1'b0;
            end
        end
        else
        begin
            ok = !((cfg.filter_mode == wffh_pkg::MODE_MGMT)
                   || (cfg.filter_mode == wffh_pkg::MODE_MESH));
        end

        ok = ok && counted && !log_full
             && (!cfg.bssid_filter_on || bssid_hit)
             && (!cfg.target_filter_on || target_hit);

        hdr = ((item.frame_kind == wffh_pkg::KIND_DATA)
               && ((item.frame_ctrl_low & wffh_pkg::QOS_MASK) == wffh_pkg::QOS_MATCH))
              ? wffh_pkg::HDR_QOS : wffh_pkg::HDR_BASIC;

        pay_diff    = item.frame_length - LW'(hdr);
        pay_clamped = '0;
        if (item.frame_length > LW'(hdr))
            pay_clamped = (pay_diff > LW'(PAYLOAD_MAX)) ? LW'(PAYLOAD_MAX) : pay_diff;

        dec.seen           = counted;
        dec.logged         = ok;
        dec.rssi           = item.signal_rssi;
        dec.frame_class    = wffh_pkg::CLS_MGMT;
        dec.frame_subtype  = '0;
        dec.header_length  = '0;
        dec.payload_length = '0;
        if (ok)
        begin
            if (item.frame_kind == wffh_pkg::KIND_DATA)
                dec.frame_class = wffh_pkg::CLS_DATA;
            else if (mesh)
                dec.frame_class = wffh_pkg::CLS_MESH;
            dec.frame_subtype  = subtype;
            dec.header_length  = hdr;
            dec.payload_length = PW'(pay_clamped);
        end
    end

endmodule

FILE: src/wffh_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wffh_stats
// Seen and per-class log counters and the last logged RSSI.
// ----------------------------------------------------------------------------
module wffh_stats
#(
    parameter int LOG_DEPTH = wffh_pkg::LOG_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                upd,
    input  wffh_pkg::decision_t dec,
    output logic                log_full,
    output wffh_pkg::report_t   report_next
);

    localparam int CNT_W = $clog2(LOG_DEPTH + 1);
    localparam int OCW   = wffh_pkg::CNT_OUT_W;

    logic [wffh_pkg::SEEN_W-1:0]        seen_reg, seen_next;
    logic [CNT_W-1:0]                   log_cnt_reg, log_cnt_next;
    logic [CNT_W-1:0]                   mgmt_cnt_reg, mgmt_cnt_next;
    logic [CNT_W-1:0]                   data_cnt_reg, data_cnt_next;
    logic [CNT_W-1:0]                   mesh_cnt_reg, mesh_cnt_next;
    logic signed [wffh_pkg::RSSI_W-1:0] rssi_reg, rssi_next;

    assign log_full = (log_cnt_reg >= CNT_W'(LOG_DEPTH));

    always_comb
    begin
        seen_next     = seen_reg;
        log_cnt_next  = log_cnt_reg;
        mgmt_cnt_next = mgmt_cnt_reg;
        data_cnt_next = data_cnt_reg;
        mesh_cnt_next = mesh_cnt_reg;
        rssi_next     = rssi_reg;
        if (upd && dec.seen)
            seen_next = seen_reg + 1'b1;
        if (upd && dec.logged)
        begin
            log_cnt_next = log_cnt_reg + 1'b1;
            rssi_next    = dec.rssi;
            case (dec.frame_class)
                wffh_pkg::CLS_DATA: data_cnt_next = data_cnt_reg + 1'b1;
                wffh_pkg::CLS_MESH: mesh_cnt_next = mesh_cnt_reg + 1'b1;
                default:            mgmt_cnt_next = mgmt_cnt_reg + 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            log_cnt_reg  <= '0;
            mgmt_cnt_reg <= '0;
            data_cnt_reg <= '0;
            mesh_cnt_reg <= '0;
            rssi_reg     <= '0;
        end
        else
        begin
            seen_reg     <= seen_next;
            log_cnt_reg  <= log_cnt_next;
            mgmt_cnt_reg <= mgmt_cnt_next;
            data_cnt_reg <= data_cnt_next;
            mesh_cnt_reg <= mesh_cnt_next;
            rssi_reg     <= rssi_next;
        end
    end

    // the result reports the counters as they stand after this item
    always_comb
    begin
        report_next.seen_total   = seen_next;
        report_next.logged_total = OCW'(log_cnt_next);
        report_next.mgmt_total   = OCW'(mgmt_cnt_next);
        report_next.data_total   = OCW'(data_cnt_next);
        report_next.mesh_total   = OCW'(mesh_cnt_next);
        report_next.log_full     = (log_cnt_next >= CNT_W'(LOG_DEPTH));
        report_next.last_rssi    = rssi_next;
    end

endmodule

FILE: src/wifi_frame_header_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wifi_frame_header_filter
// Receive-side filter and log statistics for 802.11 frame header summaries.
// ----------------------------------------------------------------------------
// Takes one header summary per clock while the output side is not stalled
// and gives exactly one result item per input item, offered from the result
// register. The item passes an input register, one pass of compare logic
// (address matches, subtype and length checks, counter increments) and a
// result register; these two registers set the one-item-per-cycle rate.
// Counters in a result are the values after that item.
// Configuration writes take effect at the next edge; the user must make them
// while no item is in flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module wifi_frame_header_filter
#(
    parameter int LOG_DEPTH   = wffh_pkg::LOG_DEPTH_DEF,
    parameter int PAYLOAD_MAX = wffh_pkg::PAYLOAD_MAX_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_we,
    input  logic [wffh_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wffh_pkg::CFG_W-1:0]            cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            frame_kind,
    input  logic [7:0]                            frame_ctrl_low,
    input  logic [wffh_pkg::ADDR_W-1:0]           address_one,
    input  logic [wffh_pkg::ADDR_W-1:0]           address_two,
    input  logic [wffh_pkg::ADDR_W-1:0]           address_three,
    input  logic [wffh_pkg::LEN_W-1:0]            frame_length,
    input  logic [wffh_pkg::OUI_W-1:0]            vendor_oui,
    input  logic signed [wffh_pkg::RSSI_W-1:0]    signal_rssi,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  logged,
    output logic [1:0]                            frame_class,
    output logic [3:0]                            frame_subtype,
    output logic [wffh_pkg::HDR_W-1:0]            header_length,
    output logic [wffh_pkg::PAY_OUT_W-1:0]        payload_length,
    output logic [wffh_pkg::SEEN_W-1:0]           seen_total,
    output logic [wffh_pkg::CNT_OUT_W-1:0]        logged_total,
    output logic [wffh_pkg::CNT_OUT_W-1:0]        mgmt_total,
    output logic [wffh_pkg::CNT_OUT_W-1:0]        data_total,
    output logic [wffh_pkg::CNT_OUT_W-1:0]        mesh_total,
    output logic                                  log_full,
    output logic signed [wffh_pkg::RSSI_W-1:0]    last_rssi
);

    wffh_pkg::cfg_t      cfg;
    wffh_pkg::item_t     item_in;
    wffh_pkg::item_t     item_reg;
    wffh_pkg::decision_t dec;
    wffh_pkg::decision_t dec_reg;
    wffh_pkg::report_t   report_next;
    wffh_pkg::report_t   report_reg;
    logic                stage_valid_reg;
    logic                out_valid_reg;
    logic                advance;
    logic                cur_full;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !stage_valid_reg || advance;

    assign item_in.frame_kind     = frame_kind;
    assign item_in.frame_ctrl_low = frame_ctrl_low;
    assign item_in.address_one    = address_one;
    assign item_in.address_two    = address_two;
    assign item_in.address_three  = address_three;
    assign item_in.frame_length   = frame_length;
    assign item_in.vendor_oui     = vendor_oui;
    assign item_in.signal_rssi    = signal_rssi;

    wffh_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wffh_classify
    #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    )
    u_classify
    (
        .item     (item_reg),
        .cfg      (cfg),
        .log_full (cur_full),
        .dec      (dec)
    );

    wffh_stats
    #(
        .LOG_DEPTH (LOG_DEPTH)
    )
    u_stats
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd         (stage_valid_reg && advance),
        .dec         (dec),
        .log_full    (cur_full),
        .report_next (report_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
                stage_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_in;
        if (stage_valid_reg && advance)
        begin
            dec_reg    <= dec;
            report_reg <= report_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign logged         = dec_reg.logged;
    assign frame_class    = dec_reg.frame_class;
    assign frame_subtype  = dec_reg.frame_subtype;
    assign header_length  = dec_reg.header_length;
    assign payload_length = dec_reg.payload_length;
    assign seen_total     = report_reg.seen_total;
    assign logged_total   = report_reg.logged_total;
    assign mgmt_total     = report_reg.mgmt_total;
    assign data_total     = report_reg.data_total;
    assign mesh_total     = report_reg.mesh_total;
    assign log_full       = report_reg.log_full;
    assign last_rssi      = report_reg.last_rssi;

endmodule

FILE: src/wffh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wffh_checker
// Port-level checks of the frame header filter, bound to the top level.
// ----------------------------------------------------------------------------
module wffh_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic                                 logged,
    input logic [1:0]                           frame_class,
    input logic [3:0]                           frame_subtype,
    input logic [wffh_pkg::HDR_W-1:0]           header_length,
    input logic [wffh_pkg::PAY_OUT_W-1:0]       payload_length,
    input logic [wffh_pkg::CNT_OUT_W-1:0]       logged_total,
    input logic [wffh_pkg::CNT_OUT_W-1:0]       mgmt_total,
    input logic [wffh_pkg::CNT_OUT_W-1:0]       data_total,
    input logic [wffh_pkg::CNT_OUT_W-1:0]       mesh_total
);

    localparam int OCW = wffh_pkg::CNT_OUT_W;

    // a stalled result item stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item withdrawn while stalled");

    // class counters always add up to the log count
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> OCW'(mgmt_total + data_total + mesh_total) == logged_total)
        else $error("class counters disagree with log count");

    // a dropped item carries no classification
    a_drop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !logged |-> frame_class == 2'd0 && frame_subtype == 4'd0
            && header_length == '0 && payload_length == '0)
        else $error("dropped item has non-zero result fields");

    // logged header is basic or qos length
    a_hdr_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && logged |-> header_length == wffh_pkg::HDR_BASIC
            || header_length == wffh_pkg::HDR_QOS)
        else $error("logged item has bad header length");

    // mesh class only comes from action frames
    a_mesh_action: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && logged && frame_class == wffh_pkg::CLS_MESH
            |-> frame_subtype == wffh_pkg::SUBTYPE_ACTION)
        else $error("mesh class on a non-action subtype");

endmodule

bind wifi_frame_header_filter wffh_checker u_wffh_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .logged         (logged),
    .frame_class    (frame_class),
    .frame_subtype  (frame_subtype),
    .header_length  (header_length),
    .payload_length (payload_length),
    .logged_total   (logged_total),
    .mgmt_total     (mgmt_total),
    .data_total     (data_total),
    .mesh_total     (mesh_total)
);
